[design/rxp_pkg.sv]
// Shared types, constants and helpers for the regex infix-to-postfix unit.
package rxp_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int GROUP_DEPTH = 16;
   localparam int OUT_DEPTH   = 64;

   localparam int TOKW = 9;
   localparam int SCW  = $clog2(STACK_DEPTH + 1);
   localparam int SAW  = $clog2(STACK_DEPTH);
   localparam int GCW  = $clog2(GROUP_DEPTH + 1);
   localparam int GAW  = $clog2(GROUP_DEPTH);
   localparam int OCW  = $clog2(OUT_DEPTH + 1);
   localparam int OAW  = $clog2(OUT_DEPTH);

   localparam logic [TOKW-1:0] JOIN_RESET = 9'd272;

   localparam logic [TOKW-1:0] CH_LBRACE = 9'd123;  // {
   localparam logic [TOKW-1:0] CH_RBRACE = 9'd125;  // }
   localparam logic [TOKW-1:0] CH_LPAR   = 9'd40;   // (
   localparam logic [TOKW-1:0] CH_RPAR   = 9'd41;   // )
   localparam logic [TOKW-1:0] CH_LBRACK = 9'd91;   // [
   localparam logic [TOKW-1:0] CH_RBRACK = 9'd93;   // ]
   localparam logic [TOKW-1:0] CH_ALT    = 9'd124;  // |
   localparam logic [TOKW-1:0] CH_STAR   = 9'd42;
   localparam logic [TOKW-1:0] CH_PLUS   = 9'd43;
   localparam logic [TOKW-1:0] CH_QMARK  = 9'd63;
   localparam logic [TOKW-1:0] CH_CARET  = 9'd94;
   localparam logic [TOKW-1:0] CH_DOLLAR = 9'd36;

   localparam logic [2:0] PRIO_POSTFIX = 3'd5;
   localparam logic [2:0] PRIO_ANCHOR  = 3'd4;
   localparam logic [2:0] PRIO_JOIN    = 3'd3;
   localparam logic [2:0] PRIO_ALT     = 3'd2;
   localparam logic [2:0] PRIO_LPAR    = 3'd1;
   localparam logic [2:0] PRIO_NONE    = 3'd0;

   typedef enum logic [2:0] {
      K_OP, K_LPAR, K_RPAR, K_LBRACE, K_LBRACK, K_PLAIN
   } kind_type;

   typedef struct packed {
      logic [TOKW-1:0] tok;
      logic            last;
      kind_type        kind;
      logic [2:0]      prio;
      logic            is_rbrace;
      logic            is_rbrack;
   } item_type;

   typedef struct packed {
      logic [SCW-1:0] op_count;
      logic [GCW-1:0] group_len;
      logic           busy;
   } stat_type;

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_CHK, S_PUSH, S_PUSHG, S_END, S_DRD, S_DLD, S_FIN
   } state_type;

   typedef enum logic [1:0] { M_GE, M_RPAR, M_FLUSH } mode_type;
   typedef enum logic [1:0] { A_PUSH, A_GROUP, A_END } after_type;

   function automatic logic [2:0] prio_of(input logic [TOKW-1:0] t,
                                         input logic [TOKW-1:0] join_tok);
      logic [2:0] p;
      priority if (t == join_tok) p = PRIO_JOIN;
      else if (t == CH_PLUS || t == CH_QMARK || t == CH_STAR || t == CH_LBRACE)
         p = PRIO_POSTFIX;
      else if (t == CH_CARET || t == CH_DOLLAR) p = PRIO_ANCHOR;
      else if (t == CH_ALT) p = PRIO_ALT;
      else if (t == CH_LPAR) p = PRIO_LPAR;
      else p = PRIO_NONE;
      return p;
   endfunction

endpackage

[design/rxp_front.sv]
// Front end: join register, token classifier and two-entry item queue.
module rxp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [rxp_pkg::TOKW-1:0] csr_wdata,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [rxp_pkg::TOKW-1:0] req_tok,
   input  logic                     req_last,
   output logic                     item_valid,
   input  logic                     item_pop,
   output rxp_pkg::item_type        item,
   output logic [rxp_pkg::TOKW-1:0] join_tok
);
   import rxp_pkg::*;

   logic [TOKW-1:0] join_ff, join_in;
   item_type        ent_ff [2];
   logic            wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]      cnt_ff, cnt_in;
   item_type        cls;
   logic            push;

   always_comb begin
      cls.tok       = req_tok;
      cls.last      = req_last;
      cls.prio      = prio_of(req_tok, join_ff);
      cls.is_rbrace = (req_tok == CH_RBRACE);
      cls.is_rbrack = (req_tok == CH_RBRACK);
      // join match outranks any ASCII meaning
      priority if (req_tok == join_ff) cls.kind = K_OP;
      else if (req_tok == CH_LPAR)   cls.kind = K_LPAR;
      else if (req_tok == CH_RPAR)   cls.kind = K_RPAR;
      else if (req_tok == CH_LBRACE) cls.kind = K_LBRACE;
      else if (req_tok == CH_LBRACK) cls.kind = K_LBRACK;
      else if (cls.prio != PRIO_NONE) cls.kind = K_OP;
      else cls.kind = K_PLAIN;
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = ent_ff[rp_ff];
   assign join_tok   = join_ff;

   always_comb begin
      join_in = csr_we ? csr_wdata : join_ff;
      wp_in   = push ? ~wp_ff : wp_ff;
      rp_in   = item_pop ? ~rp_ff : rp_ff;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         join_ff <= JOIN_RESET;
         wp_ff   <= 1'b0;
         rp_ff   <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         join_ff <= join_in;
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wp_ff] <= cls;
      end
   end

endmodule

[design/rxp_back.sv]
// Back end: operator stack, group buffer, result buffer and drain sequencer.
module rxp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   output logic                     item_pop,
   input  rxp_pkg::item_type        item,
   input  logic [rxp_pkg::TOKW-1:0] join_tok,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [rxp_pkg::TOKW-1:0] rsp_tok,
   output logic                     rsp_last,
   output logic                     rsp_err,
   output rxp_pkg::stat_type        stat
);
   import rxp_pkg::*;

   state_type       state_ff, state_in;
   mode_type        mode_ff, mode_in;
   after_type       after_ff, after_in;
   logic [SCW-1:0]  cnt_ff, cnt_in;
   logic [GCW-1:0]  glen_ff, glen_in;
   logic [OCW-1:0]  n_ff, n_in, k_ff, k_in;
   logic            in_grp_ff, in_grp_in, in_cls_ff, in_cls_in;
   logic            err_ff, err_in, unit_ff, unit_in;
   logic [2:0]      p_ff, p_in;
   logic [TOKW-1:0] tok_ff, tok_in;
   logic            last_ff, last_in;
   logic            rv_ff, rv_in, rl_ff, rl_in, re_ff, re_in;
   logic [TOKW-1:0] rt_ff, rt_in;

   logic [TOKW-1:0] stk_mem [STACK_DEPTH];
   logic [TOKW-1:0] stk_q;
   logic [TOKW-1:0] gbuf_ff [GROUP_DEPTH];
   logic [TOKW-1:0] ob_mem [OUT_DEPTH];
   logic [TOKW-1:0] ob_q;

   logic [SCW-1:0]  cm1, room;
   logic [GCW-1:0]  gm1;
   logic [OCW-1:0]  kp1;
   logic            stk_we, stk_rd, ob_rd, g_we, emit, load, fin, g_ovf;
   logic [TOKW-1:0] stk_wd, emit_tok, g_wd;
   logic [GAW-1:0]  g_wa;

   assign cm1   = cnt_ff - SCW'(1);
   assign gm1   = glen_ff - GCW'(1);
   assign kp1   = k_ff + OCW'(1);
   assign room  = SCW'(STACK_DEPTH) - cnt_ff;
   assign g_ovf = 16'(room) < 16'(glen_ff);
   assign load  = (state_ff == S_DLD) && (!rv_ff || rsp_tready);

   // loop end: either empty stack in RD or a stop condition in CHK
   always_comb begin
      fin = 1'b0;
      if (state_ff == S_RD && cnt_ff == '0) fin = 1'b1;
      if (state_ff == S_CHK && !unit_ff) begin
         unique case (mode_ff)
            M_GE:    fin = (prio_of(stk_q, join_tok) < p_ff);
            M_RPAR:  fin = (stk_q == CH_LPAR);
            M_FLUSH: fin = 1'b0;
            default: fin = 1'b0;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               if (in_cls_ff) state_in = S_END;
               else if (in_grp_ff) state_in = item.is_rbrace ? S_RD : S_END;
               else begin
                  unique case (item.kind)
                     K_OP:    state_in = S_RD;
                     K_LPAR:  state_in = S_PUSH;
                     K_RPAR:  state_in = S_RD;
                     default: state_in = S_END;
                  endcase
               end
            end
         end
         S_RD, S_CHK: begin
            if (fin) begin
               unique case (after_ff)
                  A_PUSH:  state_in = S_PUSH;
                  A_GROUP: state_in = g_ovf ? S_END : S_PUSHG;
                  default: state_in = S_END;
               endcase
            end else begin
               state_in = (state_ff == S_RD) ? S_CHK : S_RD;
            end
         end
         S_PUSH:  state_in = S_END;
         S_PUSHG: state_in = (glen_ff == GCW'(1)) ? S_END : S_PUSHG;
         S_END: begin
            if (last_ff && cnt_ff != '0) state_in = S_RD;
            else state_in = (n_ff == '0) ? S_FIN : S_DRD;
         end
         S_DRD: state_in = S_DLD;
         S_DLD: if (load) state_in = (kp1 == n_ff) ? S_FIN : S_DRD;
         S_FIN: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      mode_in   = mode_ff;
      after_in  = after_ff;
      cnt_in    = cnt_ff;
      glen_in   = glen_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      in_grp_in = in_grp_ff;
      in_cls_in = in_cls_ff;
      err_in    = err_ff;
      unit_in   = unit_ff;
      p_in      = p_ff;
      tok_in    = tok_ff;
      last_in   = last_ff;
      rt_in     = rt_ff;
      rl_in     = rl_ff;
      re_in     = re_ff;
      rv_in     = rv_ff && !rsp_tready;
      item_pop  = 1'b0;
      stk_we    = 1'b0;
      stk_wd    = tok_ff;
      stk_rd    = 1'b0;
      ob_rd     = 1'b0;
      emit      = 1'b0;
      emit_tok  = item.tok;
      g_we      = 1'b0;
      g_wa      = glen_ff[GAW-1:0];
      g_wd      = item.tok;
      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               tok_in   = item.tok;
               last_in  = item.last;
               unit_in  = 1'b0;
               mode_in  = M_GE;
               after_in = A_END;
               p_in     = item.prio;
               if (in_cls_ff) begin
                  emit = 1'b1;
                  if (item.is_rbrack) in_cls_in = 1'b0;
               end else if (in_grp_ff) begin
                  if (glen_ff < GCW'(GROUP_DEPTH)) begin
                     g_we    = 1'b1;
                     glen_in = glen_ff + GCW'(1);
                  end else begin
                     err_in = 1'b1;
                  end
                  if (item.is_rbrace) begin
                     p_in     = PRIO_POSTFIX;
                     after_in = A_GROUP;
                  end
               end else begin
                  unique case (item.kind)
                     K_OP:   after_in = A_PUSH;
                     K_LPAR: ;
                     K_RPAR: mode_in = M_RPAR;
                     K_LBRACE: begin
                        in_grp_in = 1'b1;
                        g_we      = 1'b1;
                        g_wa      = '0;
                        glen_in   = GCW'(1);
                     end
                     K_LBRACK: begin
                        in_cls_in = 1'b1;
                        emit      = 1'b1;
                     end
                     default: emit = 1'b1;
                  endcase
               end
            end
         end
         S_RD: begin
            if (cnt_ff == '0) begin
               unit_in = 1'b0;
               if (mode_ff == M_RPAR) err_in = 1'b1;
            end else begin
               stk_rd = 1'b1;
            end
         end
         S_CHK: begin
            emit_tok = stk_q;
            if (unit_ff) begin
               emit   = 1'b1;
               cnt_in = cm1;
               if (stk_q == CH_RBRACE) unit_in = 1'b0;
            end else if (mode_ff == M_FLUSH) begin
               emit   = 1'b1;
               cnt_in = cm1;
            end else if (fin) begin
               if (mode_ff == M_RPAR) cnt_in = cm1;
            end else begin
               emit    = 1'b1;
               cnt_in  = cm1;
               unit_in = (stk_q == CH_LBRACE);
            end
         end
         S_PUSH: begin
            if (cnt_ff < SCW'(STACK_DEPTH)) begin
               stk_we = 1'b1;
               cnt_in = cnt_ff + SCW'(1);
            end else begin
               err_in = 1'b1;
            end
         end
         S_PUSHG: begin
            stk_we  = 1'b1;
            stk_wd  = gbuf_ff[gm1[GAW-1:0]];
            cnt_in  = cnt_ff + SCW'(1);
            glen_in = gm1;
            if (glen_ff == GCW'(1)) in_grp_in = 1'b0;
         end
         S_END: begin
            if (last_ff && cnt_ff != '0) begin
               mode_in  = M_FLUSH;
               after_in = A_END;
               unit_in  = 1'b0;
            end
            k_in = '0;
         end
         S_DRD: ob_rd = 1'b1;
         S_DLD: begin
            if (load) begin
               rv_in = 1'b1;
               rt_in = ob_q;
               rl_in = last_ff && (kp1 == n_ff);
               re_in = err_ff;
               k_in  = kp1;
            end
         end
         S_FIN: begin
            n_in = '0;
            if (last_ff) begin
               cnt_in    = '0;
               glen_in   = '0;
               in_grp_in = 1'b0;
               in_cls_in = 1'b0;
               err_in    = 1'b0;
            end
         end
         default: ;
      endcase
      // group close: overflow drops the whole group
      if ((state_ff == S_RD || state_ff == S_CHK) && fin && after_ff == A_GROUP
          && g_ovf) begin
         err_in    = 1'b1;
         glen_in   = '0;
         in_grp_in = 1'b0;
      end
      if (emit && n_ff < OCW'(OUT_DEPTH)) n_in = n_ff + OCW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         glen_ff   <= '0;
         n_ff      <= '0;
         in_grp_ff <= 1'b0;
         in_cls_ff <= 1'b0;
         err_ff    <= 1'b0;
         unit_ff   <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         glen_ff   <= glen_in;
         n_ff      <= n_in;
         in_grp_ff <= in_grp_in;
         in_cls_ff <= in_cls_in;
         err_ff    <= err_in;
         unit_ff   <= unit_in;
         rv_ff     <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      after_ff <= after_in;
      k_ff     <= k_in;
      p_ff     <= p_in;
      tok_ff   <= tok_in;
      last_ff  <= last_in;
      rt_ff    <= rt_in;
      rl_ff    <= rl_in;
      re_ff    <= re_in;
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[cnt_ff[SAW-1:0]] <= stk_wd;
      if (stk_rd) stk_q <= stk_mem[cm1[SAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (g_we) gbuf_ff[g_wa] <= g_wd;
   end

   always_ff @(posedge clock) begin
      if (emit && n_ff < OCW'(OUT_DEPTH)) ob_mem[n_ff[OAW-1:0]] <= emit_tok;
      if (ob_rd) ob_q <= ob_mem[k_ff[OAW-1:0]];
   end

   assign rsp_tvalid     = rv_ff;
   assign rsp_tok        = rt_ff;
   assign rsp_last       = rl_ff;
   assign rsp_err        = re_ff;
   assign stat.op_count  = cnt_ff;
   assign stat.group_len = glen_ff;
   assign stat.busy      = (state_ff != S_IDLE);

endmodule

[design/regex_infix_to_postfix_unit.sv]
// Regex infix-to-postfix converter: shunting-yard over a token stream.
// Flow: a token is registered in the front queue before the back end sees it; the back end
//   dispatches it in IDLE, examines each stack entry in RD then CHK, pushes in PUSH or PUSHG
//   and drains each result in DRD then DLD. The back end handles one token at a time.
// The front queue holds two tokens, so input beats are taken while the back end works.
// Reset (synchronous, active high) empties the stack, queue and group state; join = 272.
module regex_infix_to_postfix_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [8:0] token, [15:9] zero
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [8:0] out_token, [15:9] zero
   output logic        rsp_tlast,
   output logic        rsp_tuser    // [0] error
);
   import rxp_pkg::*;

   logic            item_valid, item_pop;
   item_type        item;
   logic [TOKW-1:0] join_tok, rsp_tok;
   stat_type        stat;

   rxp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tok    (req_tdata[TOKW-1:0]),
      .req_last   (req_tlast),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item),
      .join_tok   (join_tok)
   );

   rxp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item),
      .join_tok   (join_tok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tok    (rsp_tok),
      .rsp_last   (rsp_tlast),
      .rsp_err    (rsp_tuser),
      .stat       (stat)
   );

   assign rsp_tdata = {7'd0, rsp_tok};

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      stat.op_count <= SCW'(STACK_DEPTH))
      else $error("operator stack count past depth");

   a_group_bound: assert property (@(posedge clock) disable iff (reset)
      stat.group_len <= GCW'(GROUP_DEPTH))
      else $error("group buffer length past depth");

   a_pop_busy: assert property (@(posedge clock) disable iff (reset)
      item_pop |=> stat.busy)
      else $error("token taken but back end idle");

   a_reset_out: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule
